FILE: rtl/core/fts_pkg.sv
package fts_pkg;

  localparam int unsigned CACHE_W  = 31;
  localparam int unsigned WORK_W   = 16;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned TILE_W   = 18;
  localparam int unsigned DIV_W    = 31;
  localparam int unsigned DSR_W    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BUDGET_W = 24;
  localparam int unsigned MUL_W    = 25;
  localparam int unsigned RECIP_SHIFT = 31;

  localparam int unsigned MAX_TILE = 131072;
  localparam int unsigned MIN_TILE = 8192;

  localparam logic [CACHE_W-1:0] L2_RESET = CACHE_W'(262144);
  localparam logic [CACHE_W-1:0] L3_RESET = CACHE_W'(8388608);

  // Keeping four fifths and then dividing by 68 bytes per sample equals one
  // floor division by 85. Budgets that would exceed the upper clamp are
  // saturated first, which keeps a multiply by the rounded-up reciprocal of 85
  // followed by a 31-bit shift exact.
  localparam int unsigned BUDGET_DIVISOR = 85;
  localparam logic [BUDGET_W-1:0] BUDGET_SAT = BUDGET_W'(BUDGET_DIVISOR * MAX_TILE);
  localparam logic [MUL_W-1:0] BUDGET_RECIP = MUL_W'(25264514);

  // An odd divisor divides a value exactly when the product with its inverse
  // modulo 2^18 stays within the bound, and that product is then the quotient.
  localparam logic [TILE_W-1:0] INV3  = TILE_W'(174763);
  localparam logic [TILE_W-1:0] INV5  = TILE_W'(52429);
  localparam logic [TILE_W-1:0] INV7  = TILE_W'(224695);
  localparam logic [TILE_W-1:0] QMAX3 = TILE_W'(((1 << TILE_W) - 1) / 3);
  localparam logic [TILE_W-1:0] QMAX5 = TILE_W'(((1 << TILE_W) - 1) / 5);
  localparam logic [TILE_W-1:0] QMAX7 = TILE_W'(((1 << TILE_W) - 1) / 7);

  localparam logic [CFG_IDX_W-1:0] REG_L2 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_L3 = CFG_IDX_W'(1);

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/core/fts_div.sv
module fts_div
  import fts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DIV_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/fft_tile_size_from_cache.sv
// Each accepted transaction runs the 31-step division of the level three size by
// the worker count, scales and clamps the budget, loads the candidate, searches
// it down to a 7-smooth value and emits that. The search removes factors of two
// and tests divisibility by three, five and seven, and steps the candidate down
// by one after each rejected candidate.
// Throughput: one transaction at a time. Reset (synchronous, rst_n low): idle, no result, caches 262144 and 8388608 bytes.
module fft_tile_size_from_cache
  import fts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORK_W-1:0]    in_worker_count,
  input  logic [LIMIT_W-1:0]   in_sample_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TILE_W-1:0]    out_tile_samples,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CACHE_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_CAND  = 3'd4;
  localparam logic [2:0] S_TWO   = 3'd5;
  localparam logic [2:0] S_ODD   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [1:0] P_LAST = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [CACHE_W-1:0]  l2_r, l3_r;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [BUDGET_W-1:0] bud_r, bud_nxt;
  logic [TILE_W-1:0]   cand_r, cand_nxt;
  logic [TILE_W-1:0]   m_r, m_nxt;
  logic [1:0]          p_r, p_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TILE_W-1:0]   out_tile_r, out_tile_nxt;

  div_req_t            div_req;
  div_sts_t            div_sts;
  logic [DIV_W-1:0]    div_dvd;
  logic [DSR_W-1:0]    div_dsr;
  logic [DIV_W-1:0]    div_quo;
  logic [DIV_W-1:0]    budget;
  logic [BUDGET_W-1:0] bud_sat;
  logic [DIV_W-1:0]    tile_c;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  mul_p;
  logic [TILE_W-1:0]   mul_lo;
  logic                mul_hit;

  function automatic logic [TILE_W-1:0] inv_of(input logic [1:0] p);
    case (p)
      2'd0:    inv_of = INV3;
      2'd1:    inv_of = INV5;
      default: inv_of = INV7;
    endcase
  endfunction

  function automatic logic [TILE_W-1:0] qmax_of(input logic [1:0] p);
    case (p)
      2'd0:    qmax_of = QMAX3;
      2'd1:    qmax_of = QMAX5;
      default: qmax_of = QMAX7;
    endcase
  endfunction

  fts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign budget  = (l2_r < div_quo) ? l2_r : div_quo;
  assign bud_sat = (budget > DIV_W'(BUDGET_SAT)) ? BUDGET_SAT : budget[BUDGET_W-1:0];

  always_comb begin
    mul_a = MUL_W'(m_r);
    mul_b = MUL_W'(inv_of(p_r));
    if (state_r == S_SCALE) begin
      mul_a = MUL_W'(bud_r);
      mul_b = BUDGET_RECIP;
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_lo  = mul_p[TILE_W-1:0];
  assign mul_hit = mul_lo <= qmax_of(p_r);

  always_comb begin
    tile_c = DIV_W'(cand_r);
    if (tile_c < DIV_W'(MIN_TILE)) begin
      tile_c = DIV_W'(MIN_TILE);
    end
    if (tile_c > DIV_W'(MAX_TILE)) begin
      tile_c = DIV_W'(MAX_TILE);
    end
    if (limit_r != '0 && limit_r < tile_c) begin
      tile_c = limit_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    bud_nxt       = bud_r;
    cand_nxt      = cand_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    out_tile_nxt  = out_tile_r;
    div_req.start = 1'b0;
    div_dvd       = l3_r;
    div_dsr       = (in_worker_count == '0) ? DSR_W'(1) : in_worker_count;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          limit_nxt     = in_sample_limit;
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          bud_nxt   = bud_sat;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cand_nxt  = mul_p[RECIP_SHIFT +: TILE_W];
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cand_nxt  = tile_c[TILE_W-1:0];
        state_nxt = S_CAND;
      end
      S_CAND: begin
        if (cand_r <= TILE_W'(1)) begin
          state_nxt = S_EMIT;
        end else begin
          m_nxt     = cand_r;
          state_nxt = S_TWO;
        end
      end
      S_TWO: begin
        if (m_r == TILE_W'(1)) begin
          state_nxt = S_EMIT;
        end else if (!m_r[0]) begin
          m_nxt = m_r >> 1;
        end else begin
          p_nxt     = 2'd0;
          state_nxt = S_ODD;
        end
      end
      S_ODD: begin
        if (mul_hit) begin
          m_nxt     = mul_lo;
          state_nxt = (mul_lo == TILE_W'(1)) ? S_EMIT : S_ODD;
        end else if (p_r == P_LAST) begin
          cand_nxt  = cand_r - TILE_W'(1);
          state_nxt = S_CAND;
        end else begin
          p_nxt = p_r + 2'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_tile_nxt  = cand_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      l2_r        <= L2_RESET;
      l3_r        <= L3_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_L2:  l2_r <= cfg_data;
          REG_L3:  l3_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    bud_r      <= bud_nxt;
    cand_r     <= cand_nxt;
    m_r        <= m_nxt;
    p_r        <= p_nxt;
    out_tile_r <= out_tile_nxt;
  end

  assign in_stall         = state_r != S_IDLE;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_tile_samples = out_tile_r;

  // A finished division is only expected while the sequencer waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == S_DIV)
    else $error("divider finished outside a waiting state");

  // The divider is never restarted while a division is running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // The scaled budget never exceeds the upper clamp.
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |-> cand_r <= TILE_W'(MAX_TILE))
    else $error("scaled budget above upper clamp");

  // Every emitted tile lies in one through the upper clamp.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tile_r != '0 && out_tile_r <= TILE_W'(MAX_TILE)))
    else $error("tile size out of range");

  // The reduced value never exceeds the candidate being tested.
  a_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWO || state_r == S_ODD) |-> m_r <= cand_r)
    else $error("reduced value above candidate");

endmodule

FILE: sim/tb_fft_tile_size_from_cache.sv
`timescale 1ns / 100ps

module tb_fft_tile_size_from_cache;
  import fts_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [CACHE_W-1:0] l2;
    logic [CACHE_W-1:0] l3;
    logic [WORK_W-1:0]  workers;
    logic [LIMIT_W-1:0] limit;
    logic               known;
    logic [TILE_W-1:0]  tile;
  } dir_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = CFG_IDX_W'(3);
  localparam logic [CACHE_W-1:0] CACHE_FULL = {CACHE_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_FULL = {LIMIT_W{1'b1}};
  localparam logic [TILE_W-1:0] TILE_MIN = TILE_W'(MIN_TILE);
  localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'(MAX_TILE);
  localparam int QUIET_LIMIT = 2000000;
  localparam int N_DIR = 23;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{L2_RESET, L3_RESET, 16'd0, 31'd0, 1'b1, TILE_MIN},
    '{L2_RESET, L3_RESET, 16'd1, 31'd0, 1'b1, TILE_MIN},
    '{L2_RESET, L3_RESET, 16'hFFFF, 31'd0, 1'b1, TILE_MIN},
    '{L2_RESET, L3_RESET, 16'hFFFF, LIMIT_FULL, 1'b1, TILE_MIN},
    '{L2_RESET, L3_RESET, 16'd1, 31'd1, 1'b1, 18'd1},
    '{L2_RESET, L3_RESET, 16'd7, 31'd2, 1'b1, 18'd2},
    '{L2_RESET, L3_RESET, 16'd3, 31'd11, 1'b1, 18'd10},
    '{L2_RESET, L3_RESET, 16'd2, 31'd97, 1'b1, 18'd96},
    '{L2_RESET, L3_RESET, 16'd1, 31'd8191, 1'b0, 18'd0},
    '{L2_RESET, L3_RESET, 16'd32, 31'd8192, 1'b1, TILE_MIN},
    '{L2_RESET, L3_RESET, 16'd32768, 31'h40000000, 1'b1, TILE_MIN},
    '{CACHE_FULL, CACHE_FULL, 16'd1, 31'd0, 1'b1, TILE_MAX},
    '{CACHE_FULL, CACHE_FULL, 16'd0, 31'd131071, 1'b0, 18'd0},
    '{CACHE_FULL, CACHE_FULL, 16'hFFFF, 31'd0, 1'b1, TILE_MIN},
    '{CACHE_FULL, CACHE_FULL, 16'hAAAA, 31'h55555555, 1'b0, 18'd0},
    '{31'd0, 31'd0, 16'd5, 31'd0, 1'b1, TILE_MIN},
    '{31'd0, CACHE_FULL, 16'd1, 31'd3, 1'b1, 18'd3},
    '{31'd1, 31'd1, 16'd1, 31'd0, 1'b1, TILE_MIN},
    '{31'h40000000, 31'h40000000, 16'd1, 31'd0, 1'b1, TILE_MAX},
    '{31'd4000000, CACHE_FULL, 16'd1, 31'd0, 1'b0, 18'd0},
    '{31'd4000000, CACHE_FULL, 16'd0, 31'd100000, 1'b0, 18'd0},
    '{CACHE_FULL, 31'd6000000, 16'd3, 31'd0, 1'b0, 18'd0},
    '{CACHE_FULL, 31'd6000000, 16'h5555, 31'h2AAAAAAA, 1'b0, 18'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [WORK_W-1:0] in_worker_count = '0;
  logic [LIMIT_W-1:0] in_sample_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TILE_W-1:0] out_tile_samples;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CACHE_W-1:0] cfg_data = '0;

  logic [CACHE_W-1:0] l2_bytes = L2_RESET;
  logic [CACHE_W-1:0] l3_bytes = L3_RESET;
  logic [TILE_W-1:0] pending_tiles [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_writes = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int quiet = 0;

  fft_tile_size_from_cache dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_worker_count  (in_worker_count),
    .in_sample_limit  (in_sample_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tile_samples (out_tile_samples),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_seven_smooth(logic [63:0] n);
    logic [63:0] r;
    r = n;
    if (r == 0) begin
      return 1'b0;
    end
    while (r % 2 == 0) r = r / 2;
    while (r % 3 == 0) r = r / 3;
    while (r % 5 == 0) r = r / 5;
    while (r % 7 == 0) r = r / 7;
    return r == 1;
  endfunction

  function automatic logic [TILE_W-1:0] tile_for(logic [WORK_W-1:0] w,
                                                  logic [LIMIT_W-1:0] lim);
    logic [63:0] workers;
    logic [63:0] share;
    logic [63:0] budget;
    logic [63:0] tile;
    workers = (w == 0) ? 64'd1 : 64'(w);
    share = 64'(l3_bytes) / workers;
    budget = (64'(l2_bytes) < share) ? 64'(l2_bytes) : share;
    tile = ((budget * 4) / 5) / 68;
    if (tile < MIN_TILE) begin
      tile = MIN_TILE;
    end
    if (tile > MAX_TILE) begin
      tile = MAX_TILE;
    end
    if (lim != 0 && 64'(lim) < tile) begin
      tile = 64'(lim);
    end
    while (tile > 1 && !is_seven_smooth(tile)) tile = tile - 1;
    return tile[TILE_W-1:0];
  endfunction

  function automatic logic [CACHE_W-1:0] rand_cache();
    case ($urandom_range(0, 3))
      0: begin
        return CACHE_W'($urandom);
      end
      1: begin
        return CACHE_W'($urandom_range(1, 2000000));
      end
      default: begin
        return CACHE_W'($urandom_range(400000, 12000000));
      end
    endcase
  endfunction

  task automatic flag(input string what, input logic [TILE_W-1:0] want,
                      input logic [TILE_W-1:0] got);
    errors++;
    if (errors <= 10) begin
      $display("ERROR %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic send_item(input logic [WORK_W-1:0] w, input logic [LIMIT_W-1:0] lim,
                           input logic known, input logic [TILE_W-1:0] want);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_worker_count = w;
    in_sample_limit = lim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_tiles.push_back(known ? want : tile_for(w, lim));
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CACHE_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_L2) begin
      l2_bytes = val;
    end else if (idx == REG_L3) begin
      l3_bytes = val;
    end
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_caches(input logic [CACHE_W-1:0] l2, input logic [CACHE_W-1:0] l3);
    in_valid = 1'b0;
    while (pending_tiles.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_SPARE0, CACHE_W'($urandom));
    write_reg(REG_L2, l2);
    write_reg(REG_SPARE1, CACHE_W'($urandom));
    write_reg(REG_L3, l3);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_tiles.size() == 0) begin
        flag("result with no transaction pending", '0, out_tile_samples);
      end else if (pending_tiles[0] !== out_tile_samples) begin
        flag("tile_samples mismatch", pending_tiles.pop_front(), out_tile_samples);
      end else begin
        void'(pending_tiles.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout with %0d results outstanding", pending_tiles.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [WORK_W-1:0] w;
    logic [LIMIT_W-1:0] lim;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].l2 != l2_bytes || DIR_ROWS[i].l3 != l3_bytes) begin
        load_caches(DIR_ROWS[i].l2, DIR_ROWS[i].l3);
      end
      send_item(DIR_ROWS[i].workers, DIR_ROWS[i].limit, DIR_ROWS[i].known,
                DIR_ROWS[i].tile);
    end

    for (int p = 0; p < 8; p++) begin
      load_caches(rand_cache(), rand_cache());
      case (idle_mode_e'(p % 4))
        IDLE_NONE: begin
          send_pct = 0;
          stall_pct = 0;
        end
        IDLE_SEND: begin
          send_pct = 46;
          stall_pct = 0;
        end
        IDLE_RECV: begin
          send_pct = 0;
          stall_pct = 46;
        end
        default: begin
          send_pct = 27;
          stall_pct = 27;
        end
      endcase
      repeat (36) begin
        w = ($urandom_range(0, 3) == 0) ? WORK_W'($urandom) : WORK_W'($urandom_range(0, 64));
        case ($urandom_range(0, 4))
          0, 1: lim = '0;
          2: lim = LIMIT_W'($urandom_range(1, 3000));
          3: lim = LIMIT_W'($urandom_range(1, 140000));
          default: lim = LIMIT_W'($urandom);
        endcase
        send_item(w, lim, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (pending_tiles.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);

    $display("Checked %0d tile results from %0d transactions with %0d register writes,",
             n_results, n_items, n_writes);
    $display("covering reset, zero and full-scale cache sizes and four idle patterns.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/fts_pkg.sv
rtl/core/fts_div.sv
rtl/core/fft_tile_size_from_cache.sv
sim/tb_fft_tile_size_from_cache.sv
